// ===== rtl/core/swbe_pkg.sv =====
`timescale 1ns / 1ps

package swbe_pkg;

    localparam int TIME_W  = 40;
    localparam int BYTES_W = 48;
    localparam int SAMP_W  = 32;
    localparam int WIN_W   = 11;
    localparam int IN_B_W  = 16;
    localparam int RATE_W  = 62;
    localparam int PROD_W  = 58;
    localparam int DIFF_W  = TIME_W + 2;

    localparam logic [WIN_W-1:0]   WINDOW_RESET = 11'd1000;
    localparam logic [9:0]         MS_PER_S     = 10'd1000;
    localparam logic [BYTES_W-1:0] BYTES_MAX    = {BYTES_W{1'b1}};

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        RD_OLDEST,
        RD_NEWEST,
        RD_HEAD
    } rd_sel_t;

    typedef struct packed {
        logic    latch;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    drop;
        logic    add_new;
        logic    add_upd;
        logic    q_prep;
        logic    div_step;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic full;
        logic stale;
        logic newer;
        logic is_query;
        logic q_valid;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/core/swbe_ctrl.sv =====
`timescale 1ns / 1ps

module swbe_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  swbe_pkg::sts_t  sts,
    output swbe_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_EV_RD     = 4'd1;
    localparam logic [3:0] S_EV_CHK    = 4'd2;
    localparam logic [3:0] S_ADD_RD    = 4'd3;
    localparam logic [3:0] S_ADD_CHK   = 4'd4;
    localparam logic [3:0] S_FULL_RD   = 4'd5;
    localparam logic [3:0] S_FULL_DROP = 4'd6;
    localparam logic [3:0] S_ADD_NEW   = 4'd7;
    localparam logic [3:0] S_ADD_UPD   = 4'd8;
    localparam logic [3:0] S_Q_PREP    = 4'd9;
    localparam logic [3:0] S_Q_DIV     = 4'd10;
    localparam logic [3:0] S_Q_OUT     = 4'd11;

    localparam int DC_W = $clog2(swbe_pkg::PROD_W);
    localparam logic [DC_W-1:0] DIV_LAST = DC_W'(swbe_pkg::PROD_W - 1);

    logic [3:0]      state_reg, state_next;
    logic [DC_W-1:0] dcnt_reg, dcnt_next;
    logic [3:0]      dispatch;

    assign in_stall = (state_reg != S_IDLE);
    assign dispatch = sts.is_query ? S_Q_PREP : S_ADD_RD;

    always_comb
    begin
        state_next = state_reg;
        dcnt_next  = dcnt_reg;
        cmd        = '0;
        cmd.rd_sel = swbe_pkg::RD_OLDEST;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EV_RD;
                end
            end
            S_EV_RD:
            begin
                if (sts.count_zero)
                begin
                    state_next = dispatch;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_EV_CHK;
                end
            end
            S_EV_CHK:
            begin
                if (sts.stale)
                begin
                    cmd.drop   = 1'b1;
                    state_next = S_EV_RD;
                end
                else
                begin
                    state_next = dispatch;
                end
            end
            S_ADD_RD:
            begin
                if (sts.count_zero)
                begin
                    state_next = S_ADD_NEW;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = swbe_pkg::RD_NEWEST;
                    state_next = S_ADD_CHK;
                end
            end
            S_ADD_CHK:
            begin
                if (!sts.newer)
                    state_next = S_ADD_UPD;
                else if (sts.full)
                    state_next = S_FULL_RD;
                else
                    state_next = S_ADD_NEW;
            end
            S_FULL_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = swbe_pkg::RD_HEAD;
                state_next = S_FULL_DROP;
            end
            S_FULL_DROP:
            begin
                cmd.drop   = 1'b1;
                state_next = S_ADD_NEW;
            end
            S_ADD_NEW:
            begin
                cmd.add_new = 1'b1;
                state_next  = S_IDLE;
            end
            S_ADD_UPD:
            begin
                cmd.add_upd = 1'b1;
                state_next  = S_IDLE;
            end
            S_Q_PREP:
            begin
                cmd.q_prep = 1'b1;
                dcnt_next  = '0;
                state_next = S_Q_DIV;
            end
            S_Q_DIV:
            begin
                if (!sts.q_valid)
                begin
                    state_next = S_Q_OUT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    dcnt_next    = dcnt_reg + 1'b1;
                    if (dcnt_reg == DIV_LAST)
                        state_next = S_Q_OUT;
                end
            end
            S_Q_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_Q_DIV) |-> (dcnt_reg <= DIV_LAST))
        else $error("divider step count out of range");
    a_drop_only_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop |-> !sts.count_zero)
        else $error("drop issued on empty ring");
    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |=> (state_reg == S_EV_RD))
        else $error("accepted item did not start eviction");

endmodule

// ===== rtl/core/swbe_dp.sv =====
`timescale 1ns / 1ps

module swbe_dp #(
    parameter int MAX_BUCKETS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [swbe_pkg::WIN_W-1:0]          cfg_wdata,
    input  logic                                operation,
    input  logic [swbe_pkg::IN_B_W-1:0]         byte_count,
    input  logic [swbe_pkg::TIME_W-1:0]         time_ms,
    input  swbe_pkg::cmd_t                      cmd,
    output swbe_pkg::sts_t                      sts,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [swbe_pkg::RATE_W-1:0]         rate_bps,
    output logic                                rate_valid
);

    localparam int AW = $clog2(MAX_BUCKETS);
    localparam int CW = $clog2(MAX_BUCKETS + 1);
    localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_BUCKETS);
    localparam logic [AW-1:0] ADDR_TOP = AW'(MAX_BUCKETS - 1);
    localparam logic [CW:0]   RING_SZ  = (CW+1)'(MAX_BUCKETS);

    localparam int TW = swbe_pkg::TIME_W;
    localparam int BW = swbe_pkg::BYTES_W;
    localparam int SW = swbe_pkg::SAMP_W;
    localparam int WW = swbe_pkg::WIN_W;
    localparam int PW = swbe_pkg::PROD_W;
    localparam int DW = swbe_pkg::DIFF_W;

    logic [TW-1:0] mem_time  [MAX_BUCKETS];
    logic [BW-1:0] mem_bytes [MAX_BUCKETS];
    logic [SW-1:0] mem_samp  [MAX_BUCKETS];

    logic                           op_reg;
    logic [swbe_pkg::IN_B_W-1:0]    bytes_reg;
    logic [TW-1:0]                  now_reg;
    logic [WW-1:0]                  win_reg;
    logic [AW-1:0]                  head_reg, head_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [BW-1:0]                  wb_reg, wb_next;
    logic [SW-1:0]                  ws_reg, ws_next;
    logic [TW-1:0]                  ft_reg, ft_next;
    logic                           fs_reg, fs_next;
    logic                           ovf_reg, ovf_next;
    logic [TW-1:0]                  rd_time_reg;
    logic [BW-1:0]                  rd_bytes_reg;
    logic [SW-1:0]                  rd_samp_reg;
    logic [WW-1:0]                  act_reg;
    logic                           qv_reg;
    logic [WW-1:0]                  rem_reg;
    logic [PW-1:0]                  quo_reg;
    logic                           out_valid_reg;
    logic [swbe_pkg::RATE_W-1:0]    rate_reg;
    logic                           rv_reg;

    logic [CW:0]   head_ext;
    logic [CW:0]   oldest_ext;
    logic [AW-1:0] oldest;
    logic [AW-1:0] newest;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [TW-1:0] wr_time;
    logic [BW-1:0] wr_bytes;
    logic [SW-1:0] wr_samp;
    logic [BW-1:0] in_bytes_ext;
    logic          fits;
    logic          win_full;
    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] active;
    logic signed [DW-1:0] win_s;
    logic          q_ok;
    logic [WW:0]   trial;
    logic          trial_ge;

    assign head_ext   = {1'b0, {(CW-AW){1'b0}}, head_reg};
    assign oldest_ext = (head_ext >= {1'b0, count_reg}) ? head_ext - {1'b0, count_reg}
                                                         : head_ext + RING_SZ - {1'b0, count_reg};
    assign oldest     = oldest_ext[AW-1:0];
    assign newest     = (head_reg == '0) ? ADDR_TOP : head_reg - 1'b1;
    assign head_inc   = (head_reg == ADDR_TOP) ? '0 : head_reg + 1'b1;

    always_comb
    begin
        case (cmd.rd_sel)
            swbe_pkg::RD_OLDEST: rd_addr = oldest;
            swbe_pkg::RD_NEWEST: rd_addr = newest;
            swbe_pkg::RD_HEAD:   rd_addr = head_reg;
            default:             rd_addr = oldest;
        endcase
    end

    assign in_bytes_ext = {{(BW-swbe_pkg::IN_B_W){1'b0}}, bytes_reg};
    assign fits         = (swbe_pkg::BYTES_MAX - wb_reg) > in_bytes_ext;

    assign wr_addr  = cmd.add_new ? head_reg : newest;
    assign wr_time  = cmd.add_new ? now_reg : rd_time_reg;
    assign wr_bytes = cmd.add_new ? in_bytes_ext : rd_bytes_reg + in_bytes_ext;
    assign wr_samp  = cmd.add_new ? SW'(1) : rd_samp_reg + 1'b1;

    assign win_full = ({1'b0, ft_reg} + {{(TW+1-WW){1'b0}}, win_reg}) <= {1'b0, now_reg};
    assign diff     = $signed({2'b00, now_reg}) - $signed({2'b00, ft_reg}) + DW'(1);
    assign win_s    = $signed({{(DW-WW){1'b0}}, win_reg});
    assign active   = !fs_reg ? '0 : (win_full ? win_s : diff);
    assign q_ok     = fs_reg && (ws_reg != '0) && (active > DW'(1))
                      && !((ws_reg <= SW'(1)) && (active < win_s)) && !ovf_reg;

    assign trial    = {rem_reg, quo_reg[PW-1]};
    assign trial_ge = trial >= {1'b0, act_reg};

    assign sts.count_zero = (count_reg == '0);
    assign sts.full       = (count_reg == CNT_MAX);
    assign sts.stale      = ({1'b0, rd_time_reg} + {{(TW+1-WW){1'b0}}, win_reg})
                            <= {1'b0, now_reg};
    assign sts.newer      = now_reg > rd_time_reg;
    assign sts.is_query   = (op_reg == swbe_pkg::OP_QUERY);
    assign sts.q_valid    = qv_reg;
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign rate_bps   = rate_reg;
    assign rate_valid = rv_reg;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        wb_next    = wb_reg;
        ws_next    = ws_reg;
        ft_next    = ft_reg;
        fs_next    = fs_reg;
        ovf_next   = ovf_reg;
        if (cmd.drop)
        begin
            wb_next    = wb_reg - rd_bytes_reg;
            ws_next    = ws_reg - rd_samp_reg;
            count_next = count_reg - 1'b1;
        end
        if (cmd.add_new || cmd.add_upd)
        begin
            if (!fs_reg)
            begin
                ft_next = now_reg;
                fs_next = 1'b1;
            end
            if (fits)
                wb_next = wb_reg + in_bytes_ext;
            else
                ovf_next = 1'b1;
            ws_next = ws_reg + 1'b1;
        end
        if (cmd.add_new)
        begin
            head_next  = head_inc;
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= swbe_pkg::WINDOW_RESET;
            head_reg      <= '0;
            count_reg     <= '0;
            wb_reg        <= '0;
            ws_reg        <= '0;
            ft_reg        <= '0;
            fs_reg        <= 1'b0;
            ovf_reg       <= 1'b0;
            qv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                win_reg <= cfg_wdata;
            head_reg  <= head_next;
            count_reg <= count_next;
            wb_reg    <= wb_next;
            ws_reg    <= ws_next;
            ft_reg    <= ft_next;
            fs_reg    <= fs_next;
            ovf_reg   <= ovf_next;
            if (cmd.q_prep)
                qv_reg <= q_ok;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= operation;
            bytes_reg <= byte_count;
            now_reg   <= time_ms;
        end
        if (cmd.rd_en)
        begin
            rd_time_reg  <= mem_time[rd_addr];
            rd_bytes_reg <= mem_bytes[rd_addr];
            rd_samp_reg  <= mem_samp[rd_addr];
        end
        if (cmd.add_new || cmd.add_upd)
        begin
            mem_time[wr_addr]  <= wr_time;
            mem_bytes[wr_addr] <= wr_bytes;
            mem_samp[wr_addr]  <= wr_samp;
        end
        if (cmd.q_prep)
        begin
            act_reg <= active[WW-1:0];
            rem_reg <= '0;
            quo_reg <= PW'(wb_reg) * PW'(swbe_pkg::MS_PER_S);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? WW'(trial - {1'b0, act_reg}) : trial[WW-1:0];
            quo_reg <= {quo_reg[PW-2:0], trial_ge};
        end
        if (cmd.out_load)
        begin
            rate_reg <= qv_reg ? {1'b0, quo_reg, 3'b000} : '0;
            rv_reg   <= qv_reg;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_MAX) && (head_reg <= ADDR_TOP))
        else $error("ring pointer out of range");
    a_drop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("drop did not shrink ring");
    a_new_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_new |=> ((count_reg == $past(count_reg) + 1'b1) && fs_reg))
        else $error("new bucket did not grow ring");

endmodule

// ===== rtl/core/sliding_window_bitrate_estimator_top.sv =====
// Sliding-window bit rate estimator. Each item is either an add (operation 0), which puts
// byte_count into the per-millisecond bucket for time_ms, or a query (operation 1), which
// returns one result item of (bytes * 1000 / active window) * 8 bits per second. Buckets live in
// a ring of MAX_BUCKETS entries held in one single-port memory per field, so every bucket that
// ages out of the window is read and compared before the item's own work, and the oldest bucket
// is read and compared to confirm it is still current (skipped when the ring is empty). An add
// then reads the newest bucket and updates it or opens a new one, first dropping the head bucket
// if the ring is full. A query runs the restoring divider (one quotient bit per cycle over a
// 58-bit dividend, skipped for an invalid estimate) and waits while the previous result stalls.
// The memories need no clearing after reset. Write window_ms only while no item is in flight.
`timescale 1ns / 1ps

module sliding_window_bitrate_estimator_top #(
    parameter int MAX_BUCKETS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [swbe_pkg::WIN_W-1:0]       cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             operation,
    input  logic [swbe_pkg::IN_B_W-1:0]      byte_count,
    input  logic [swbe_pkg::TIME_W-1:0]      time_ms,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [swbe_pkg::RATE_W-1:0]      rate_bps,
    output logic                             rate_valid
);

    swbe_pkg::cmd_t cmd;
    swbe_pkg::sts_t sts;

    swbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    swbe_dp #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .operation  (operation),
        .byte_count (byte_count),
        .time_ms    (time_ms),
        .cmd        (cmd),
        .sts        (sts),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .rate_bps   (rate_bps),
        .rate_valid (rate_valid)
    );

endmodule
